// File: rtl/rri_pkg.sv
// ----------------------------------------------------------------------------
// rri_pkg: ray / parallelogram intersection types and constants
// Shared field widths, request and result payloads, register indexes.
// ----------------------------------------------------------------------------
package rri_pkg;

    localparam int COMP_W    = 20;   // one signed vector component
    localparam int DIST_W    = 19;   // unsigned distance
    localparam int REG_W     = 60;   // three packed components
    localparam int CFG_IDX_W = 3;

    typedef logic signed [COMP_W-1:0] t_comp;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CORNER   = 3'd0,
        CFG_EDGE_A   = 3'd1,
        CFG_EDGE_B   = 3'd2,
        CFG_NORMAL   = 3'd3,
        CFG_MIN_DIST = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COMP_W-1:0] origin_x;
        logic signed [COMP_W-1:0] origin_y;
        logic signed [COMP_W-1:0] origin_z;
        logic signed [COMP_W-1:0] dir_x;
        logic signed [COMP_W-1:0] dir_y;
        logic signed [COMP_W-1:0] dir_z;
    } t_ray;

    typedef struct packed {
        logic                     hit;
        logic        [DIST_W-1:0] distance;
        logic signed [COMP_W-1:0] hit_x;
        logic signed [COMP_W-1:0] hit_y;
        logic signed [COMP_W-1:0] hit_z;
    } t_hit;

    // component i of a packed vector register, x in the low bits
    function automatic t_comp comp_of(input logic [REG_W-1:0] r, input int unsigned i);
        comp_of = t_comp'(r[COMP_W*i +: COMP_W]);
    endfunction

endpackage

// File: rtl/rri_ray_if.sv
// ----------------------------------------------------------------------------
// rri_ray_if: ray request channel
// Valid/ready channel carrying one ray per request.
// ----------------------------------------------------------------------------
interface rri_ray_if;
    logic         valid;
    logic         ready;
    rri_pkg::t_ray data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/rri_hit_if.sv
// ----------------------------------------------------------------------------
// rri_hit_if: intersection result channel
// Valid/ready channel carrying one hit record per request.
// ----------------------------------------------------------------------------
interface rri_hit_if;
    logic         valid;
    logic         ready;
    rri_pkg::t_hit data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ray_rectangle_intersect_core.sv
// ----------------------------------------------------------------------------
// ray_rectangle_intersect_core: ray / parallelogram intersection pipeline
// One request per cycle sustained while the output is not stalled.
// The distance divide is an overflow check followed by a 19-stage restoring
// divider, one quotient bit a stage.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Synchronous active-low reset clears valid bits and loads the register
// defaults (all zero, min_distance one LSB).
// ----------------------------------------------------------------------------
module ray_rectangle_intersect_core #(
    parameter int FRAC_BITS = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rri_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rri_pkg::REG_W-1:0]          i_cfg_data,
    rri_ray_if.sink                            i_ray,
    rri_hit_if.source                          o_hit
);
    import rri_pkg::*;

    localparam int W_W   = COMP_W + 1;            // corner minus origin
    localparam int NUM_W = 2*W_W + 1;              // 43
    localparam int DEN_W = 2*COMP_W + 2;           // 42
    localparam int N_W   = NUM_W + FRAC_BITS;
    localparam int REM_W = (N_W > DEN_W + DIST_W) ? N_W : DEN_W + DIST_W;
    localparam int PR_W  = 2*COMP_W;               // t * dir
    localparam int PF_W  = PR_W + 1;
    localparam int DP_W  = W_W + COMP_W;           // d * edge
    localparam int DS_W  = DP_W + 2;
    localparam int LS_W  = 2*COMP_W + 2;

    // configuration
    logic [REG_W-1:0]  r_corner, r_edge_a, r_edge_b, r_normal;
    logic [DIST_W-1:0] r_min_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner   <= '0;
            r_edge_a   <= '0;
            r_edge_b   <= '0;
            r_normal   <= '0;
            r_min_dist <= DIST_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CORNER:   r_corner   <= i_cfg_data;
                CFG_EDGE_A:   r_edge_a   <= i_cfg_data;
                CFG_EDGE_B:   r_edge_b   <= i_cfg_data;
                CFG_NORMAL:   r_normal   <= i_cfg_data;
                CFG_MIN_DIST: r_min_dist <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    t_comp c [3], ea [3], eb [3], nv [3], in_o [3], in_d [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c[i]  = comp_of(r_corner, i);
            ea[i] = comp_of(r_edge_a, i);
            eb[i] = comp_of(r_edge_b, i);
            nv[i] = comp_of(r_normal, i);
        end
        in_o[0] = i_ray.data.origin_x;
        in_o[1] = i_ray.data.origin_y;
        in_o[2] = i_ray.data.origin_z;
        in_d[0] = i_ray.data.dir_x;
        in_d[1] = i_ray.data.dir_y;
        in_d[2] = i_ray.data.dir_z;
    end

    logic r_out_v;
    t_hit r_out;
    logic en;
    assign en          = !r_out_v || o_hit.ready;
    assign i_ray.ready = en;
    assign o_hit.valid = r_out_v;
    assign o_hit.data  = r_out;

    // stage 1: w = corner - origin
    logic                    r_s1_v;
    t_comp                   r_s1_o [3], r_s1_d [3];
    logic signed [W_W-1:0]   r_s1_w [3];

    // stage 2: products for numerator and denominator
    logic                      r_s2_v;
    t_comp                     r_s2_o [3], r_s2_d [3];
    logic signed [2*W_W-2:0]   r_s2_pw [3];
    logic signed [PR_W-1:0]    r_s2_pd [3];

    // stage 3: sums
    logic                      r_s3_v;
    t_comp                     r_s3_o [3], r_s3_d [3];
    logic signed [NUM_W-1:0]   r_s3_num;
    logic signed [DEN_W-1:0]   r_s3_den;

    // stage 4: magnitudes and sign check
    logic                      r_s4_v, r_s4_miss;
    t_comp                     r_s4_o [3], r_s4_d [3];
    logic [REM_W-1:0]          r_s4_rem;
    logic [DEN_W-1:0]          r_s4_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_ray.valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    logic [NUM_W-1:0] nmag;
    logic [DEN_W-1:0] dmag;
    always_comb begin
        nmag = r_s3_num[NUM_W-1] ? NUM_W'(~r_s3_num + 1'b1) : NUM_W'(r_s3_num);
        dmag = r_s3_den[DEN_W-1] ? DEN_W'(~r_s3_den + 1'b1) : DEN_W'(r_s3_den);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_o[i]  <= in_o[i];
                r_s1_d[i]  <= in_d[i];
                r_s1_w[i]  <= W_W'(c[i]) - W_W'(in_o[i]);
                r_s2_o[i]  <= r_s1_o[i];
                r_s2_d[i]  <= r_s1_d[i];
                r_s2_pw[i] <= r_s1_w[i] * nv[i];
                r_s2_pd[i] <= r_s1_d[i] * nv[i];
                r_s3_o[i]  <= r_s2_o[i];
                r_s3_d[i]  <= r_s2_d[i];
                r_s4_o[i]  <= r_s3_o[i];
                r_s4_d[i]  <= r_s3_d[i];
            end
            r_s3_num <= NUM_W'(r_s2_pw[0]) + NUM_W'(r_s2_pw[1]) + NUM_W'(r_s2_pw[2]);
            r_s3_den <= DEN_W'(r_s2_pd[0]) + DEN_W'(r_s2_pd[1]) + DEN_W'(r_s2_pd[2]);
            // zero divisor, or numerator and divisor of opposite sign
            r_s4_miss <= (r_s3_den == '0) ||
                         (r_s3_num != '0 && (r_s3_num[NUM_W-1] != r_s3_den[DEN_W-1]));
            r_s4_rem  <= REM_W'({nmag, FRAC_BITS'(0)});
            r_s4_den  <= dmag;
        end
    end

    // divider: entry 0 after the overflow check, entry g+1 after bit DIST_W-1-g
    logic              r_dv_v    [DIST_W+1];
    logic              r_dv_miss [DIST_W+1];
    logic [REM_W-1:0]  r_dv_rem  [DIST_W+1];
    logic [DEN_W-1:0]  r_dv_den  [DIST_W+1];
    logic [DIST_W-1:0] r_dv_q    [DIST_W+1];
    t_comp             r_dv_o    [DIST_W+1][3];
    t_comp             r_dv_d    [DIST_W+1][3];

    logic [REM_W-1:0] ovf_lim;
    assign ovf_lim = REM_W'({r_s4_den, DIST_W'(0)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // quotient would not fit the distance field
            r_dv_miss[0] <= r_s4_miss || (r_s4_rem >= ovf_lim);
            r_dv_rem[0]  <= r_s4_rem;
            r_dv_den[0]  <= r_s4_den;
            r_dv_q[0]    <= '0;
            for (int i = 0; i < 3; i++) begin
                r_dv_o[0][i] <= r_s4_o[i];
                r_dv_d[0][i] <= r_s4_d[i];
            end
        end
    end

    for (genvar g = 0; g < DIST_W; g++) begin : g_div
        localparam int K = DIST_W - 1 - g;
        logic [REM_W-1:0]  sh;
        logic              ge;
        logic [DIST_W-1:0] n_q;
        always_comb begin
            sh     = REM_W'(r_dv_den[g]) << K;
            ge     = r_dv_rem[g] >= sh;
            n_q    = r_dv_q[g];
            n_q[K] = ge;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[g+1] <= 1'b0;
            end else if (en) begin
                r_dv_v[g+1] <= r_dv_v[g];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_miss[g+1] <= r_dv_miss[g];
                r_dv_rem[g+1]  <= ge ? r_dv_rem[g] - sh : r_dv_rem[g];
                r_dv_den[g+1]  <= r_dv_den[g];
                r_dv_q[g+1]    <= n_q;
                for (int i = 0; i < 3; i++) begin
                    r_dv_o[g+1][i] <= r_dv_o[g][i];
                    r_dv_d[g+1][i] <= r_dv_d[g][i];
                end
            end
        end
    end

    // t * dir
    logic                   r_mu_v, r_mu_miss;
    logic [DIST_W-1:0]      r_mu_q;
    t_comp                  r_mu_o [3];
    logic signed [PR_W-1:0] r_mu_p [3];

    // hit point, range check, offset from corner
    logic                   r_p_v, r_p_miss;
    logic [DIST_W-1:0]      r_p_q;
    t_comp                  r_p_pt [3];
    logic signed [W_W-1:0]  r_p_dd [3];

    // projections onto the edges and squared edge lengths
    logic                   r_dt_v, r_dt_miss;
    logic [DIST_W-1:0]      r_dt_q;
    t_comp                  r_dt_pt [3];
    logic signed [DP_W-1:0] r_dt_pa [3], r_dt_pb [3];
    logic signed [PR_W-1:0] r_dt_sa [3], r_dt_sb [3];

    // sums
    logic                   r_sm_v, r_sm_miss;
    logic [DIST_W-1:0]      r_sm_q;
    t_comp                  r_sm_pt [3];
    logic signed [DS_W-1:0] r_sm_da, r_sm_db;
    logic signed [LS_W-1:0] r_sm_la, r_sm_lb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu_v  <= 1'b0;
            r_p_v   <= 1'b0;
            r_dt_v  <= 1'b0;
            r_sm_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_mu_v  <= r_dv_v[DIST_W];
            r_p_v   <= r_mu_v;
            r_dt_v  <= r_p_v;
            r_sm_v  <= r_dt_v;
            r_out_v <= r_sm_v;
        end
    end

    logic signed [PF_W-1:0] pf [3];
    logic                   p_ovr;
    always_comb begin
        p_ovr = 1'b0;
        for (int i = 0; i < 3; i++) begin
            // arithmetic shift rounds toward minus infinity
            pf[i] = PF_W'(r_mu_o[i]) + PF_W'(r_mu_p[i] >>> FRAC_BITS);
            if (pf[i] > PF_W'(signed'({1'b0, {(COMP_W-1){1'b1}}})) ||
                pf[i] < -PF_W'(signed'({1'b0, 1'b1, {(COMP_W-1){1'b0}}})))
                p_ovr = 1'b1;
        end
    end

    logic h_ok;
    assign h_ok = !r_sm_miss && !r_sm_da[DS_W-1] && (DS_W'(r_sm_la) >= r_sm_da) &&
                  !r_sm_db[DS_W-1] && (DS_W'(r_sm_lb) >= r_sm_db);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mu_miss <= r_dv_miss[DIST_W] || (r_dv_q[DIST_W] <= r_min_dist);
            r_mu_q    <= r_dv_q[DIST_W];
            for (int i = 0; i < 3; i++) begin
                r_mu_o[i] <= r_dv_o[DIST_W][i];
                r_mu_p[i] <= signed'({1'b0, r_dv_q[DIST_W]}) * r_dv_d[DIST_W][i];
            end

            r_p_miss <= r_mu_miss || p_ovr;
            r_p_q    <= r_mu_q;
            for (int i = 0; i < 3; i++) begin
                r_p_pt[i] <= t_comp'(pf[i][COMP_W-1:0]);
                r_p_dd[i] <= W_W'(t_comp'(pf[i][COMP_W-1:0])) - W_W'(c[i]);
            end

            r_dt_miss <= r_p_miss;
            r_dt_q    <= r_p_q;
            for (int i = 0; i < 3; i++) begin
                r_dt_pt[i] <= r_p_pt[i];
                r_dt_pa[i] <= r_p_dd[i] * ea[i];
                r_dt_pb[i] <= r_p_dd[i] * eb[i];
                r_dt_sa[i] <= ea[i] * ea[i];
                r_dt_sb[i] <= eb[i] * eb[i];
            end

            r_sm_miss <= r_dt_miss;
            r_sm_q    <= r_dt_q;
            for (int i = 0; i < 3; i++)
                r_sm_pt[i] <= r_dt_pt[i];
            r_sm_da <= DS_W'(r_dt_pa[0]) + DS_W'(r_dt_pa[1]) + DS_W'(r_dt_pa[2]);
            r_sm_db <= DS_W'(r_dt_pb[0]) + DS_W'(r_dt_pb[1]) + DS_W'(r_dt_pb[2]);
            r_sm_la <= LS_W'(r_dt_sa[0]) + LS_W'(r_dt_sa[1]) + LS_W'(r_dt_sa[2]);
            r_sm_lb <= LS_W'(r_dt_sb[0]) + LS_W'(r_dt_sb[1]) + LS_W'(r_dt_sb[2]);

            r_out.hit      <= h_ok;
            r_out.distance <= h_ok ? r_sm_q : '0;
            r_out.hit_x    <= h_ok ? r_sm_pt[0] : '0;
            r_out.hit_y    <= h_ok ? r_sm_pt[1] : '0;
            r_out.hit_z    <= h_ok ? r_sm_pt[2] : '0;
        end
    end

endmodule
